FILE: src/mahd_pkg.sv
// ----------------------------------------------------------------------------
// mahd_pkg - shared types and constants of the audio frame header decoder
// tables, widths and the sideband record carried down the pipeline
// ----------------------------------------------------------------------------
package mahd_pkg;

    localparam int NUM_W          = 27;  // frame length dividend
    localparam int DEN_W          = 16;  // sample rate divisor
    localparam int QUO_W          = 12;  // frame length quotient
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

    localparam logic [1:0] VER_MPEG1  = 2'd0;
    localparam logic [1:0] VER_MPEG2  = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    localparam logic [1:0] LAYER_RSVD = 2'd0;
    localparam logic [1:0] LAYER_1    = 2'd1;
    localparam logic [1:0] LAYER_2    = 2'd2;
    localparam logic [1:0] LAYER_3    = 2'd3;

    localparam logic [1:0] MODE_MONO  = 2'd3;

    localparam logic [10:0] SPF_L1     = 11'd384;
    localparam logic [10:0] SPF_LONG   = 11'd1152;
    localparam logic [10:0] SPF_SHORT  = 11'd576;

    // bytes-per-frame scale: 12*1000 for layer I, spf/8*1000 otherwise
    localparam logic [17:0] SCALE_L1    = 18'd12000;
    localparam logic [17:0] SCALE_LONG  = 18'd144000;
    localparam logic [17:0] SCALE_SHORT = 18'd72000;

    localparam logic [8:0] BR_TABLE [3][3][16] = '{
        '{
            '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
              9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
            '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
              9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
        },
        '{
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
        },
        '{
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
        }
    };

    localparam logic [15:0] SR_TABLE [3][4] = '{
        '{16'd44100, 16'd48000, 16'd32000, 16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd11025, 16'd12000, 16'd8000,  16'd0}
    };

    // decoded header fields travelling beside the length datapath
    typedef struct packed {
        logic        valid_res;
        logic [1:0]  version_code;
        logic [1:0]  layer;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic [1:0]  channel_mode;
        logic [1:0]  mode_extension;
        logic [4:0]  flag_bits;
        logic [1:0]  emphasis;
        logic [1:0]  channels;
        logic [10:0] samples_per_frame;
        logic        pad;
    } t_side;

endpackage

FILE: src/mpeg_audio_header_decoder_unit.sv
// ----------------------------------------------------------------------------
// throughput: one header transaction per cycle, busy is never raised
// nine register stages: decode, product, six two-bit divider stages, output
// synchronous active-low reset clears all valid bits; no result is pending after it
// the receiver cannot stall, each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder_unit - audio frame header parser
// unpacks a 32-bit frame header, looks up bitrate and sample rate, checks
// legality and works out samples per frame and frame length in bytes
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_header_word,
    output logic        o_strobe,
    output logic        o_valid_res,
    output logic [1:0]  o_version_code,
    output logic [1:0]  o_layer,
    output logic [8:0]  o_bitrate_kbps,
    output logic [15:0] o_sample_rate_hz,
    output logic [1:0]  o_channel_mode,
    output logic [1:0]  o_mode_extension,
    output logic [4:0]  o_flag_bits,
    output logic [1:0]  o_emphasis,
    output logic [1:0]  o_channels,
    output logic [10:0] o_samples_per_frame,
    output logic [11:0] o_frame_bytes
);

    // pipeline never holds off a transaction
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // stage 1: field unpack, table lookups, legality check
    // ---------------------------------------------------------------
    logic            r_s1_vld;
    mahd_pkg::t_side r_s1;
    mahd_pkg::t_side n_s1;

    always_comb begin
        logic       sync_ok;
        logic [1:0] ver;
        logic [1:0] lay;
        logic [1:0] lay_idx;
        logic [8:0] br;
        logic [15:0] sr;
        logic       ok;

        // 11 sync bits; bit 20 doubles as the version extension bit
        sync_ok = &i_header_word[31:21];

        if (!i_header_word[20]) begin
            ver = mahd_pkg::VER_MPEG25;
        end else if (i_header_word[19]) begin
            ver = mahd_pkg::VER_MPEG1;
        end else begin
            ver = mahd_pkg::VER_MPEG2;
        end

        // layer code 3 means layer I, 0 is reserved
        lay     = 2'(2'd0 - i_header_word[18:17]);
        lay_idx = (lay == mahd_pkg::LAYER_RSVD) ? 2'd0 : 2'(lay - 2'd1);

        br = mahd_pkg::BR_TABLE[ver][lay_idx][i_header_word[15:12]];
        sr = mahd_pkg::SR_TABLE[ver][i_header_word[11:10]];
        if (lay == mahd_pkg::LAYER_RSVD) begin
            br = '0;
            sr = '0;
        end

        ok = sync_ok && (lay != mahd_pkg::LAYER_RSVD) && (br != '0) && (sr != '0);

        n_s1.valid_res      = ok;
        n_s1.version_code   = ver;
        n_s1.layer          = lay;
        n_s1.bitrate_kbps   = ok ? br : 9'd0;
        n_s1.sample_rate_hz = ok ? sr : 16'd0;
        n_s1.channel_mode   = i_header_word[7:6];
        n_s1.mode_extension = i_header_word[5:4];
        // crc present is the inverted protection bit
        n_s1.flag_bits      = {i_header_word[2], i_header_word[3], i_header_word[8],
                               i_header_word[9], ~i_header_word[16]};
        n_s1.emphasis       = i_header_word[1:0];
        n_s1.channels       = (i_header_word[7:6] == mahd_pkg::MODE_MONO) ? 2'd1 : 2'd2;
        n_s1.pad            = i_header_word[9];

        case (lay)
            mahd_pkg::LAYER_1: begin
                n_s1.samples_per_frame = mahd_pkg::SPF_L1;
            end
            mahd_pkg::LAYER_2: begin
                n_s1.samples_per_frame = mahd_pkg::SPF_LONG;
            end
            mahd_pkg::LAYER_3: begin
                n_s1.samples_per_frame = (ver == mahd_pkg::VER_MPEG1) ?
                                         mahd_pkg::SPF_LONG : mahd_pkg::SPF_SHORT;
            end
            default: begin
                n_s1.samples_per_frame = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // stage 2: dividend = bitrate * slot scale, divisor = sample rate
    // invalid headers carry zeros and are masked at the end
    // ---------------------------------------------------------------
    logic                       r_s2_vld;
    mahd_pkg::t_side            r_s2;
    logic [mahd_pkg::NUM_W-1:0] r_s2_num;
    logic [mahd_pkg::DEN_W-1:0] r_s2_den;
    logic [mahd_pkg::NUM_W-1:0] n_s2_num;
    logic [17:0]                s2_scale;
    logic [26:0]                s2_prod;

    always_comb begin
        if (r_s1.layer == mahd_pkg::LAYER_1) begin
            s2_scale = mahd_pkg::SCALE_L1;
        end else if (r_s1.samples_per_frame == mahd_pkg::SPF_LONG) begin
            s2_scale = mahd_pkg::SCALE_LONG;
        end else begin
            s2_scale = mahd_pkg::SCALE_SHORT;
        end
        // both operands widened so the full 27-bit product is kept
        s2_prod  = 27'(r_s1.bitrate_kbps) * 27'(s2_scale);
        n_s2_num = mahd_pkg::NUM_W'(s2_prod);
    end

    // ---------------------------------------------------------------
    // stages 3 to 8: frame length division
    // ---------------------------------------------------------------
    logic                       div_vld;
    logic [mahd_pkg::QUO_W-1:0] div_quo;
    mahd_pkg::t_side            div_side;

    mahd_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .i_num   (r_s2_num),
        .i_den   (r_s2_den),
        .i_side  (r_s2),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // ---------------------------------------------------------------
    // stage 9: padding, layer I slot scaling, output register
    // ---------------------------------------------------------------
    logic [11:0] n_len;
    logic [11:0] len_sum;

    always_comb begin
        len_sum = div_quo + {11'd0, div_side.pad};
        if (!div_side.valid_res) begin
            n_len = '0;
        end else if (div_side.layer == mahd_pkg::LAYER_1) begin
            // layer I counts 4-byte slots
            n_len = {len_sum[9:0], 2'b00};
        end else begin
            n_len = len_sum;
        end
    end

    logic            r_out_vld;
    mahd_pkg::t_side r_out;
    logic [11:0]     r_out_len;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= start && !busy;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= div_vld;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_s1      <= n_s1;
        r_s2      <= r_s1;
        r_s2_num  <= n_s2_num;
        r_s2_den  <= r_s1.sample_rate_hz;
        r_out     <= div_side;
        r_out_len <= n_len;
    end

    assign o_strobe            = r_out_vld;
    assign o_valid_res         = r_out.valid_res;
    assign o_version_code      = r_out.version_code;
    assign o_layer             = r_out.layer;
    assign o_bitrate_kbps      = r_out.bitrate_kbps;
    assign o_sample_rate_hz    = r_out.sample_rate_hz;
    assign o_channel_mode      = r_out.channel_mode;
    assign o_mode_extension    = r_out.mode_extension;
    assign o_flag_bits         = r_out.flag_bits;
    assign o_emphasis          = r_out.emphasis;
    assign o_channels          = r_out.channels;
    assign o_samples_per_frame = r_out.samples_per_frame;
    assign o_frame_bytes       = r_out_len;

endmodule

FILE: src/mahd_div_pipe.sv
// ----------------------------------------------------------------------------
// mahd_div_pipe - pipelined restoring divider for the frame length
// two quotient bits per stage, sideband record travels with each slot
// ----------------------------------------------------------------------------
module mahd_div_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [mahd_pkg::NUM_W-1:0] i_num,
    input  logic [mahd_pkg::DEN_W-1:0] i_den,
    input  mahd_pkg::t_side            i_side,
    output logic                       o_vld,
    output logic [mahd_pkg::QUO_W-1:0] o_quo,
    output mahd_pkg::t_side            o_side
);

    typedef struct packed {
        logic [mahd_pkg::NUM_W-1:0] rem;
        logic [mahd_pkg::DEN_W-1:0] den;
        logic [mahd_pkg::QUO_W-1:0] quo;
        mahd_pkg::t_side            side;
    } t_div_slot;

    logic      r_vld [mahd_pkg::DIV_STAGES];
    t_div_slot r_dat [mahd_pkg::DIV_STAGES];
    t_div_slot n_dat [mahd_pkg::DIV_STAGES];

    always_comb begin
        t_div_slot                cur;
        logic [mahd_pkg::NUM_W:0] shifted;
        int                       j;
        for (int k = 0; k < mahd_pkg::DIV_STAGES; k++) begin
            if (k == 0) begin
                cur.rem  = i_num;
                cur.den  = i_den;
                cur.quo  = '0;
                cur.side = i_side;
            end else begin
                cur = r_dat[k-1];
            end
            for (int b = 0; b < mahd_pkg::BITS_PER_STAGE; b++) begin
                j = mahd_pkg::QUO_W - 1 - k * mahd_pkg::BITS_PER_STAGE - b;
                shifted = {{(mahd_pkg::NUM_W + 1 - mahd_pkg::DEN_W){1'b0}}, cur.den} << j;
                if ({1'b0, cur.rem} >= shifted) begin
                    cur.rem    = cur.rem - shifted[mahd_pkg::NUM_W-1:0];
                    cur.quo[j] = 1'b1;
                end
            end
            n_dat[k] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < mahd_pkg::DIV_STAGES; k++) begin
            r_dat[k] <= n_dat[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mahd_pkg::DIV_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < mahd_pkg::DIV_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_vld  = r_vld[mahd_pkg::DIV_STAGES-1];
    assign o_quo  = r_dat[mahd_pkg::DIV_STAGES-1].quo;
    assign o_side = r_dat[mahd_pkg::DIV_STAGES-1].side;

endmodule

FILE: dv/header_decode_checker.sv
// ----------------------------------------------------------------------------
// header_decode_checker - scoreboard for the audio frame header decoder
// decodes every accepted header word on its own and compares the result
// fields, oldest first, against what the decoder strobes out
// ----------------------------------------------------------------------------
module header_decode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_header_word,
    input  logic        i_strobe,
    input  logic        i_valid_res,
    input  logic [1:0]  i_version_code,
    input  logic [1:0]  i_layer,
    input  logic [8:0]  i_bitrate_kbps,
    input  logic [15:0] i_sample_rate_hz,
    input  logic [1:0]  i_channel_mode,
    input  logic [1:0]  i_mode_extension,
    input  logic [4:0]  i_flag_bits,
    input  logic [1:0]  i_emphasis,
    input  logic [1:0]  i_channels,
    input  logic [10:0] i_samples_per_frame,
    input  logic [11:0] i_frame_bytes,
    output int          o_failures,
    output int          o_pending
);

    // bitrates in kbps: mpeg-1 per layer, then the low sample rate versions
    localparam int KBPS_V1 [3][16] = '{
        '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
        '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
    };
    localparam int KBPS_LSF [2][16] = '{
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    };
    // mpeg-2 halves and mpeg-2.5 quarters the mpeg-1 rates
    localparam int FS_BASE [3] = '{44100, 48000, 32000};

    typedef struct packed {
        logic [31:0] word;
        logic        valid;
        logic [1:0]  version;
        logic [1:0]  layer;
        logic [8:0]  kbps;
        logic [15:0] hz;
        logic [1:0]  mode;
        logic [1:0]  joint_ext;
        logic [4:0]  flags;
        logic [1:0]  emph;
        logic [1:0]  chans;
        logic [10:0] spf;
        logic [11:0] bytes;
    } t_decoded_header;

    t_decoded_header pending_decodes [$];

    function automatic t_decoded_header decode_header(input logic [31:0] w);
        t_decoded_header d;
        int kbps;
        int hz;
        int spf;
        int len;
        d = '0;
        d.word = w;
        if (!w[20]) begin
            d.version = mahd_pkg::VER_MPEG25;
        end else begin
            d.version = w[19] ? mahd_pkg::VER_MPEG1 : mahd_pkg::VER_MPEG2;
        end
        case (w[18:17])
            2'b11: d.layer = mahd_pkg::LAYER_1;
            2'b10: d.layer = mahd_pkg::LAYER_2;
            2'b01: d.layer = mahd_pkg::LAYER_3;
            default: d.layer = mahd_pkg::LAYER_RSVD;
        endcase
        kbps = 0;
        hz = 0;
        spf = 0;
        len = 0;
        if (d.layer != mahd_pkg::LAYER_RSVD) begin
            if (d.version == mahd_pkg::VER_MPEG1) begin
                kbps = KBPS_V1[int'(d.layer) - 1][w[15:12]];
            end else begin
                kbps = KBPS_LSF[(d.layer == mahd_pkg::LAYER_1) ? 0 : 1][w[15:12]];
            end
            hz = (w[11:10] == 2'b11) ? 0 : (FS_BASE[w[11:10]] >> d.version);
            if (d.layer == mahd_pkg::LAYER_1) begin
                spf = 384;
            end else if (d.layer == mahd_pkg::LAYER_2
                         || d.version == mahd_pkg::VER_MPEG1) begin
                spf = 1152;
            end else begin
                spf = 576;
            end
        end
        d.valid = (w[31:21] == 11'h7ff) && (d.layer != mahd_pkg::LAYER_RSVD)
                  && kbps != 0 && hz != 0;
        if (d.valid) begin
            // layer i counts four-byte slots, padding is one slot
            if (d.layer == mahd_pkg::LAYER_1) begin
                len = ((12 * kbps * 1000) / hz + int'(w[9])) * 4;
            end else begin
                len = ((spf / 8) * kbps * 1000) / hz + int'(w[9]);
            end
        end else begin
            kbps = 0;
            hz = 0;
        end
        d.kbps = 9'(kbps);
        d.hz = 16'(hz);
        d.spf = 11'(spf);
        d.bytes = 12'(len);
        d.mode = w[7:6];
        d.joint_ext = w[5:4];
        d.flags = {w[2], w[3], w[8], w[9], ~w[16]};
        d.emph = w[1:0];
        d.chans = (w[7:6] == mahd_pkg::MODE_MONO) ? 2'd1 : 2'd2;
        return d;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] word,
                                 input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: header %h field %s expected %0d actual %0d",
                     $time, word, name, want, got);
            o_failures++;
        end
    endtask

    initial begin
        o_failures = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : monitor
        t_decoded_header want;
        if (i_rst_n) begin
            // results first so a combinational output cannot match its own input
            if (i_strobe) begin
                if (pending_decodes.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none actual %h",
                             $time, {i_valid_res, i_frame_bytes});
                    o_failures++;
                end else begin
                    want = pending_decodes.pop_front();
                    compare_field("valid_res", want.word, want.valid, i_valid_res);
                    compare_field("version_code", want.word, want.version, i_version_code);
                    compare_field("layer", want.word, want.layer, i_layer);
                    compare_field("bitrate_kbps", want.word, want.kbps, i_bitrate_kbps);
                    compare_field("sample_rate_hz", want.word, want.hz, i_sample_rate_hz);
                    compare_field("channel_mode", want.word, want.mode, i_channel_mode);
                    compare_field("mode_extension", want.word, want.joint_ext,
                                  i_mode_extension);
                    compare_field("flag_bits", want.word, want.flags, i_flag_bits);
                    compare_field("emphasis", want.word, want.emph, i_emphasis);
                    compare_field("channels", want.word, want.chans, i_channels);
                    compare_field("samples_per_frame", want.word, want.spf,
                                  i_samples_per_frame);
                    compare_field("frame_bytes", want.word, want.bytes, i_frame_bytes);
                end
            end
            if (i_start && !i_busy) begin
                pending_decodes.push_back(decode_header(i_header_word));
            end
        end
        o_pending = pending_decodes.size();
    end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - audio frame header decoder
// directed headers on every version, layer and table corner, then a long
// run of mostly well-formed random headers with random idle bursts; the
// checker beside the decoder predicts and compares every transaction
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_HEADERS = 800;
    localparam int CALM_TAIL      = 100;  // final stretch sent back to back
    localparam int STALL_LIMIT    = 500;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 20;   // idle time after the final drain

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] header_word = '0;

    logic        busy;
    logic        o_strobe;
    logic        o_valid_res;
    logic [1:0]  o_version_code;
    logic [1:0]  o_layer;
    logic [8:0]  o_bitrate_kbps;
    logic [15:0] o_sample_rate_hz;
    logic [1:0]  o_channel_mode;
    logic [1:0]  o_mode_extension;
    logic [4:0]  o_flag_bits;
    logic [1:0]  o_emphasis;
    logic [1:0]  o_channels;
    logic [10:0] o_samples_per_frame;
    logic [11:0] o_frame_bytes;

    int failures;
    int pending;
    int stall_count = 0;

    // 20-unit clock period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    mpeg_audio_header_decoder_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_header_word      (header_word),
        .o_strobe           (o_strobe),
        .o_valid_res        (o_valid_res),
        .o_version_code     (o_version_code),
        .o_layer            (o_layer),
        .o_bitrate_kbps     (o_bitrate_kbps),
        .o_sample_rate_hz   (o_sample_rate_hz),
        .o_channel_mode     (o_channel_mode),
        .o_mode_extension   (o_mode_extension),
        .o_flag_bits        (o_flag_bits),
        .o_emphasis         (o_emphasis),
        .o_channels         (o_channels),
        .o_samples_per_frame(o_samples_per_frame),
        .o_frame_bytes      (o_frame_bytes)
    );

    header_decode_checker checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_header_word      (header_word),
        .i_strobe           (o_strobe),
        .i_valid_res        (o_valid_res),
        .i_version_code     (o_version_code),
        .i_layer            (o_layer),
        .i_bitrate_kbps     (o_bitrate_kbps),
        .i_sample_rate_hz   (o_sample_rate_hz),
        .i_channel_mode     (o_channel_mode),
        .i_mode_extension   (o_mode_extension),
        .i_flag_bits        (o_flag_bits),
        .i_emphasis         (o_emphasis),
        .i_channels         (o_channels),
        .i_samples_per_frame(o_samples_per_frame),
        .i_frame_bytes      (o_frame_bytes),
        .o_failures         (failures),
        .o_pending          (pending)
    );

    // watchdog: any accepted header or strobed result counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // header with sync set and the named fields forced, the rest random
    function automatic logic [31:0] header_with(input logic [1:0] ver_bits,
                                                input logic [1:0] layer_bits,
                                                input logic [3:0] rate_idx,
                                                input logic [1:0] fs_idx,
                                                input logic       pad,
                                                input logic [1:0] mode);
        logic [31:0] w;
        w = $urandom;
        w[31:21] = 11'h7ff;
        w[20:19] = ver_bits;
        w[18:17] = layer_bits;
        w[15:12] = rate_idx;
        w[11:10] = fs_idx;
        w[9]     = pad;
        w[7:6]   = mode;
        return w;
    endfunction

    // mostly legal headers with random content, then sync-only and pure noise
    function automatic logic [31:0] random_header();
        logic [31:0] w;
        int kind;
        kind = $urandom_range(0, 9);
        w = $urandom;
        if (kind <= 7) begin
            w[31:21] = 11'h7ff;
        end
        if (kind <= 5) begin
            w[18:17] = 2'($urandom_range(1, 3));
            w[15:12] = 4'($urandom_range(1, 14));
            w[11:10] = 2'($urandom_range(0, 2));
        end
        return w;
    endfunction

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send_header(input logic [31:0] w);
        logic was_free;
        start <= 1'b1;
        header_word <= w;
        do begin
            // busy only moves on a rising edge, so the falling edge is a safe look
            @(negedge i_clk);
            was_free = !busy;
            @(posedge i_clk);
        end while (!was_free);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        header_word <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        bit idling;
        idling = 1'b1;

        // synchronous reset held low, then released
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_header(32'h0000_0000);
        send_header(32'hffff_ffff);
        // largest bitrate of each mpeg-1 layer at 32 khz, padded
        send_header(header_with(2'b11, 2'b11, 4'd14, 2'd2, 1'b1, 2'd3));
        send_header(header_with(2'b11, 2'b10, 4'd14, 2'd2, 1'b1, 2'd0));
        send_header(header_with(2'b11, 2'b01, 4'd14, 2'd2, 1'b1, 2'd1));
        // lowest bitrate, 44.1 khz, truncating division
        send_header(header_with(2'b11, 2'b01, 4'd1, 2'd0, 1'b0, 2'd2));
        hold_off(3);
        // mpeg-2 on every layer
        send_header(header_with(2'b10, 2'b11, 4'd14, 2'd1, 1'b0, 2'd0));
        send_header(header_with(2'b10, 2'b10, 4'd14, 2'd2, 1'b1, 2'd1));
        send_header(header_with(2'b10, 2'b01, 4'd1, 2'd2, 1'b0, 2'd3));
        // mpeg-2.5 layer ii at 8 khz: the longest frame there is
        send_header(header_with(2'b00, 2'b10, 4'd14, 2'd2, 1'b1, 2'd2));
        // version bit clear wins over the low version bit
        send_header(header_with(2'b01, 2'b01, 4'd8, 2'd0, 1'b1, 2'd1));
        send_header(header_with(2'b01, 2'b11, 4'd1, 2'd1, 1'b0, 2'd3));
        // reserved layer, free format, bad bitrate index, reserved sample rate
        send_header(header_with(2'b11, 2'b00, 4'd5, 2'd0, 1'b0, 2'd0));
        send_header(header_with(2'b11, 2'b10, 4'd0, 2'd1, 1'b1, 2'd0));
        send_header(header_with(2'b10, 2'b01, 4'd15, 2'd0, 1'b0, 2'd1));
        send_header(header_with(2'b00, 2'b11, 4'd7, 2'd3, 1'b1, 2'd2));
        // broken sync: lowest sync bit, then the top bit
        send_header(header_with(2'b11, 2'b10, 4'd9, 2'd0, 1'b0, 2'd0) & ~32'h0020_0000);
        send_header(header_with(2'b11, 2'b10, 4'd9, 2'd0, 1'b0, 2'd0) & ~32'h8000_0000);
        // every flag bit but crc present (left random) set, then every flag bit clear
        send_header(header_with(2'b11, 2'b01, 4'd9, 2'd1, 1'b1, 2'd3) | 32'h0000_013f);
        send_header(header_with(2'b11, 2'b01, 4'd9, 2'd1, 1'b0, 2'd1) & ~32'h0001_013f
                    | 32'h0001_0000);
        drain_results();

        // random part, with one full drain half way through
        for (int n = 0; n < RANDOM_HEADERS; n++) begin
            if (n % 64 == 0) begin
                idling = ($urandom_range(0, 3) != 0);
            end
            if (n == RANDOM_HEADERS / 2) begin
                drain_results();
            end
            if (idling && n < RANDOM_HEADERS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
                hold_off($urandom_range(1, 12));
            end
            send_header(random_header());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
